// ===== hdl/irdim_pkg.sv =====
// Shared types and constants for the remote-controlled RGB dimmer.
// Used by irdim_core, irdim_skid and ir_rgb_dimmer_pwm; no dependencies.
package irdim_pkg;

    localparam int DUTY_W   = 12;
    localparam int STEP_W   = 8;
    localparam int PERIOD_W = 13;
    localparam int CFG_W    = 13;
    localparam int CODE_W   = 64;

    localparam logic [DUTY_W-1:0]   DUTY_MAX        = 12'd4095;
    localparam logic [DUTY_W-1:0]   DUTY_RESET      = 12'd750;
    localparam logic [STEP_W-1:0]   STEP_RESET      = 8'd50;
    localparam logic [DUTY_W-1:0]   RED_LIMIT_RESET = 12'd1000;
    localparam logic [DUTY_W-1:0]   GB_LIMIT_RESET  = 12'd850;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 13'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN      = 13'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX      = 13'd4096;

    localparam logic [CODE_W-1:0] CODE_POWER      = 64'd3974070404;
    localparam logic [CODE_W-1:0] CODE_ALL_DOWN   = 64'd2140684872;
    localparam logic [CODE_W-1:0] CODE_ALL_UP     = 64'd3321326852;
    localparam logic [CODE_W-1:0] CODE_RED_UP     = 64'd825816032;
    localparam logic [CODE_W-1:0] CODE_GREEN_UP   = 64'd3207847040;
    localparam logic [CODE_W-1:0] CODE_BLUE_UP    = 64'd2880933152;
    localparam logic [CODE_W-1:0] CODE_RED_DOWN   = 64'd1250339008;
    localparam logic [CODE_W-1:0] CODE_GREEN_DOWN = 64'd3222488448;
    localparam logic [CODE_W-1:0] CODE_BLUE_DOWN  = 64'd3121764036;
    localparam logic [CODE_W-1:0] CODE_REPEAT     = {CODE_W{1'b1}};

    typedef enum logic [1:0] {
        CFG_DUTY_STEP  = 2'd0,
        CFG_RED_LIMIT  = 2'd1,
        CFG_GB_LIMIT   = 2'd2,
        CFG_PWM_PERIOD = 2'd3
    } cfg_idx_t;

    // result word, lowest field last so it packs straight onto tdata
    typedef struct packed {
        logic              lamp_is_on;
        logic [DUTY_W-1:0] blue_duty_now;
        logic [DUTY_W-1:0] green_duty_now;
        logic [DUTY_W-1:0] red_duty_now;
        logic              blue_level;
        logic              green_level;
        logic              red_level;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// ===== hdl/irdim_core.sv =====
// Dimmer state: config registers, duties, enables, repeat key and PWM counter.
// Computes one result per accepted request. Depends on irdim_pkg.
module irdim_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_addr,
    input  logic [irdim_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                in_accept,
    input  logic                                in_action,
    input  logic [irdim_pkg::CODE_W-1:0]        in_code,
    output irdim_pkg::result_t                  result
);

    typedef enum logic [3:0] {
        KEY_NONE,
        KEY_TOGGLE,
        KEY_ALL_DOWN,
        KEY_ALL_UP,
        KEY_RED_UP,
        KEY_GREEN_UP,
        KEY_BLUE_UP,
        KEY_RED_DOWN,
        KEY_GREEN_DOWN,
        KEY_BLUE_DOWN
    } key_t;

    localparam int DW = irdim_pkg::DUTY_W;

    logic [irdim_pkg::STEP_W-1:0]   step_reg;
    logic [DW-1:0]                  red_limit_reg;
    logic [DW-1:0]                  gb_limit_reg;
    logic [irdim_pkg::PERIOD_W-1:0] period_reg;

    logic [DW-1:0] duty_reg  [3];
    logic [DW-1:0] duty_next [3];
    logic [2:0]    en_reg, en_next;
    logic          lamp_reg, lamp_next;
    key_t          last_key_reg, last_key_next;
    logic [DW-1:0] count_reg, count_next;

    key_t                           key_dec, key_eff;
    logic [2:0]                     raise_mask, lower_mask;
    logic [DW-1:0]                  limit     [3];
    logic [DW:0]                    sum       [3];
    logic [irdim_pkg::PERIOD_W-1:0] period_eff;
    logic [DW:0]                    count_inc;
    logic [2:0]                     level;

    always_comb begin
        unique case (in_code)
            irdim_pkg::CODE_POWER:      key_dec = KEY_TOGGLE;
            irdim_pkg::CODE_ALL_DOWN:   key_dec = KEY_ALL_DOWN;
            irdim_pkg::CODE_ALL_UP:     key_dec = KEY_ALL_UP;
            irdim_pkg::CODE_RED_UP:     key_dec = KEY_RED_UP;
            irdim_pkg::CODE_GREEN_UP:   key_dec = KEY_GREEN_UP;
            irdim_pkg::CODE_BLUE_UP:    key_dec = KEY_BLUE_UP;
            irdim_pkg::CODE_RED_DOWN:   key_dec = KEY_RED_DOWN;
            irdim_pkg::CODE_GREEN_DOWN: key_dec = KEY_GREEN_DOWN;
            irdim_pkg::CODE_BLUE_DOWN:  key_dec = KEY_BLUE_DOWN;
            default:                    key_dec = KEY_NONE;
        endcase
        if (in_code == irdim_pkg::CODE_REPEAT && last_key_reg != KEY_NONE) begin
            key_eff = last_key_reg;
        end else begin
            key_eff = key_dec;
        end

        unique case (key_eff)
            KEY_ALL_DOWN:   begin raise_mask = 3'b000; lower_mask = 3'b111; end
            KEY_ALL_UP:     begin raise_mask = 3'b111; lower_mask = 3'b000; end
            KEY_RED_UP:     begin raise_mask = 3'b001; lower_mask = 3'b000; end
            KEY_GREEN_UP:   begin raise_mask = 3'b010; lower_mask = 3'b000; end
            KEY_BLUE_UP:    begin raise_mask = 3'b100; lower_mask = 3'b000; end
            KEY_RED_DOWN:   begin raise_mask = 3'b000; lower_mask = 3'b001; end
            KEY_GREEN_DOWN: begin raise_mask = 3'b000; lower_mask = 3'b010; end
            KEY_BLUE_DOWN:  begin raise_mask = 3'b000; lower_mask = 3'b100; end
            default:        begin raise_mask = 3'b000; lower_mask = 3'b000; end
        endcase

        // effective period clamped to 1..4096
        priority if (period_reg == '0) begin
            period_eff = irdim_pkg::PERIOD_MIN;
        end else if (period_reg > irdim_pkg::PERIOD_MAX) begin
            period_eff = irdim_pkg::PERIOD_MAX;
        end else begin
            period_eff = period_reg;
        end
        count_inc = {1'b0, count_reg} + {{DW{1'b0}}, 1'b1};

        duty_next     = duty_reg;
        en_next       = en_reg;
        lamp_next     = lamp_reg;
        last_key_next = last_key_reg;
        count_next    = count_reg;

        for (int ch = 0; ch < 3; ch++) begin
            limit[ch] = (ch == 0) ? red_limit_reg : gb_limit_reg;
            sum[ch]   = {1'b0, duty_reg[ch]} + {{(DW + 1 - irdim_pkg::STEP_W){1'b0}}, step_reg};
        end

        if (in_accept) begin
            if (in_action) begin
                if (count_inc >= period_eff) begin
                    count_next = '0;
                end else begin
                    count_next = count_inc[DW-1:0];
                end
            end else if (key_eff == KEY_TOGGLE) begin
                lamp_next = !lamp_reg;
                en_next   = {3{!lamp_reg}};
            end else if (key_eff == KEY_NONE) begin
                last_key_next = KEY_NONE;
            end else begin
                last_key_next = key_eff;
                for (int ch = 0; ch < 3; ch++) begin
                    if (raise_mask[ch]) begin
                        en_next[ch] = 1'b1;
                        if (duty_reg[ch] < limit[ch]) begin
                            duty_next[ch] = sum[ch][DW] ? irdim_pkg::DUTY_MAX : sum[ch][DW-1:0];
                        end
                    end
                    if (lower_mask[ch]) begin
                        if (en_reg[ch] && duty_reg[ch] != '0) begin
                            duty_next[ch] = (duty_reg[ch] > {{(DW - irdim_pkg::STEP_W){1'b0}}, step_reg})
                                ? duty_reg[ch] - {{(DW - irdim_pkg::STEP_W){1'b0}}, step_reg}
                                : '0;
                        end else begin
                            en_next[ch] = 1'b0;
                        end
                    end
                end
            end
        end

        // pins use the counter as it stood before this request
        for (int ch = 0; ch < 3; ch++) begin
            level[ch] = lamp_next && en_next[ch] && (duty_next[ch] >= count_reg);
        end
        result.red_level      = level[0];
        result.green_level    = level[1];
        result.blue_level     = level[2];
        result.red_duty_now   = duty_next[0];
        result.green_duty_now = duty_next[1];
        result.blue_duty_now  = duty_next[2];
        result.lamp_is_on     = lamp_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= irdim_pkg::STEP_RESET;
            red_limit_reg <= irdim_pkg::RED_LIMIT_RESET;
            gb_limit_reg  <= irdim_pkg::GB_LIMIT_RESET;
            period_reg    <= irdim_pkg::PERIOD_RESET;
        end else if (cfg_we) begin
            unique case (irdim_pkg::cfg_idx_t'(cfg_addr))
                irdim_pkg::CFG_DUTY_STEP:  step_reg      <= cfg_wdata[irdim_pkg::STEP_W-1:0];
                irdim_pkg::CFG_RED_LIMIT:  red_limit_reg <= cfg_wdata[DW-1:0];
                irdim_pkg::CFG_GB_LIMIT:   gb_limit_reg  <= cfg_wdata[DW-1:0];
                irdim_pkg::CFG_PWM_PERIOD: period_reg    <= cfg_wdata[irdim_pkg::PERIOD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int ch = 0; ch < 3; ch++) begin
                duty_reg[ch] <= irdim_pkg::DUTY_RESET;
            end
            en_reg       <= 3'b111;
            lamp_reg     <= 1'b1;
            last_key_reg <= KEY_NONE;
            count_reg    <= '0;
        end else begin
            duty_reg     <= duty_next;
            en_reg       <= en_next;
            lamp_reg     <= lamp_next;
            last_key_reg <= last_key_next;
            count_reg    <= count_next;
        end
    end

    // a replayed key keeps itself as the repeat key
    a_repeat_keeps_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !in_action && in_code == irdim_pkg::CODE_REPEAT
         && last_key_reg != KEY_NONE) |=> $stable(last_key_reg))
        else $error("repeat request changed the stored key");

    // ticks never touch duties, enables or power
    a_tick_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_action) |=> ($stable(en_reg) && $stable(lamp_reg)
         && $stable(duty_reg[0]) && $stable(duty_reg[1]) && $stable(duty_reg[2])))
        else $error("tick request altered dimmer state");

    // codes leave the PWM counter alone
    a_code_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && !in_action) |=> $stable(count_reg))
        else $error("code request moved the PWM counter");

endmodule

// ===== hdl/irdim_skid.sv =====
// Output register with one skid entry for the result channel.
// Depends on irdim_pkg for the result type.
module irdim_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  irdim_pkg::result_t in_data,
    output logic               in_ready,
    output logic               out_valid,
    output irdim_pkg::result_t out_data,
    input  logic               out_ready
);

    logic               main_valid_reg, main_valid_next;
    irdim_pkg::result_t main_data_reg,  main_data_next;
    logic               skid_valid_reg, skid_valid_next;
    irdim_pkg::result_t skid_data_reg,  skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                main_data_next  = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved on to the output");

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_ready) |=> (main_data_reg == $past(skid_data_reg)))
        else $error("skid entry lost on the way to the output");

endmodule

// ===== hdl/ir_rgb_dimmer_pwm.sv =====
// Top level of the remote-controlled three-channel LED dimmer with PWM.
// Instantiates irdim_core and irdim_skid; uses irdim_pkg.
//
// Input requests arrive on s_ (tuser = action, tdata = 64-bit remote code).
// action 0 decodes a key (power, all up/down, per-channel up/down, repeat);
// action 1 is one PWM tick that drives the pins and advances the counter.
// Every request gives exactly one result on m_: the three pin levels, the
// three duties after the request and the lamp power bit.
// Results are registered. Throughput: one request per cycle while s_tready
// is high; state is updated on acceptance so the next request sees it.
// The result register has one skid entry behind it, so s_tready stays high
// for one more request after m_tready drops, and falls while the skid entry
// is occupied. No request is lost or repeated under any stall pattern.
// Reset (aresetn low, synchronous): duties 750, lamp on, all channels
// enabled, no repeat key, counter 0, registers to their defaults; no
// result pending. Config writes (cfg_we) take effect on the next edge and
// should only be issued while no results are outstanding.
module ir_rgb_dimmer_pwm (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_addr,
    input  logic [irdim_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // [63:0] ir_code
    input  logic                        s_tuser,   // [0] action
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [0] red_level, [1] green_level, [2] blue_level, [14:3] red_duty_now,
    // [26:15] green_duty_now, [38:27] blue_duty_now, [39] lamp_is_on
    output logic [39:0]                 m_tdata
);

    logic               accept;
    irdim_pkg::result_t core_result;
    irdim_pkg::result_t out_result;

    assign accept  = s_tvalid && s_tready;
    assign m_tdata = out_result;

    irdim_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_accept (accept),
        .in_action (s_tuser),
        .in_code   (s_tdata),
        .result    (core_result)
    );

    irdim_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_data   (core_result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_result),
        .out_ready (m_tready)
    );

endmodule
